/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker file sm83_alu_chk.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Condition that must hold at every edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("assertion failed");

`endif

/* rtl/sm83_alu_pkg.sv */
// ----------------------------------------------------------------------------
// sm83_alu_pkg
// Operation codes, flag positions and widths of the SM83 ALU.
// ----------------------------------------------------------------------------
package sm83_alu_pkg;

    localparam int OP_W   = 5;
    localparam int DATA_W = 8;
    localparam int FLAG_W = 4;

    // Pipeline depth from an accepted start to the done strobe
    localparam int LATENCY = 2;

    localparam logic [OP_W-1:0] OP_ADD  = 5'd0;
    localparam logic [OP_W-1:0] OP_ADC  = 5'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 5'd2;
    localparam logic [OP_W-1:0] OP_SBC  = 5'd3;
    localparam logic [OP_W-1:0] OP_AND  = 5'd4;
    localparam logic [OP_W-1:0] OP_XOR  = 5'd5;
    localparam logic [OP_W-1:0] OP_OR   = 5'd6;
    localparam logic [OP_W-1:0] OP_CP   = 5'd7;
    localparam logic [OP_W-1:0] OP_INC  = 5'd8;
    localparam logic [OP_W-1:0] OP_DEC  = 5'd9;
    localparam logic [OP_W-1:0] OP_RLCA = 5'd10;
    localparam logic [OP_W-1:0] OP_RRCA = 5'd11;
    localparam logic [OP_W-1:0] OP_RLA  = 5'd12;
    localparam logic [OP_W-1:0] OP_RRA  = 5'd13;
    localparam logic [OP_W-1:0] OP_DAA  = 5'd14;
    localparam logic [OP_W-1:0] OP_CPL  = 5'd15;
    localparam logic [OP_W-1:0] OP_SCF  = 5'd16;
    localparam logic [OP_W-1:0] OP_CCF  = 5'd17;

    // Flag bit positions
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    localparam logic [DATA_W-1:0] DAA_HI  = 8'h60;
    localparam logic [DATA_W-1:0] DAA_LO  = 8'h06;
    localparam logic [DATA_W-1:0] BCD_MAX = 8'h99;
    localparam logic [3:0]        NIB_MAX = 4'h9;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [DATA_W-1:0] acc_value;
        logic [DATA_W-1:0] operand;
        logic [FLAG_W-1:0] flags_in;
    } alu_req_t;

endpackage

/* rtl/sm83_alu_with_flags_top.sv */
// ----------------------------------------------------------------------------
// sm83_alu_with_flags_top
// SM83 8-bit ALU with Z/N/H/C flags, one operation per clock.
// ----------------------------------------------------------------------------
//  channel  | handshake     | payload
//  ---------+---------------+--------------------------------------------
//  command  | start / busy  | opcode, acc_value, operand, flags_in
//  result   | done (strobe) | result, flags_out
//
//  A transfer on the command side happens at an edge with start high and busy
//  low; busy stays low, so one operation can enter every cycle.
//  The path runs through the input register, then the ALU logic into the result
//  register, whose done strobe lasts one cycle.
//  rst_n clears the two valid bits asynchronously; payload is not reset.
//  The receiver cannot stall, so nothing ever waits inside the block.
// ----------------------------------------------------------------------------
module sm83_alu_with_flags_top
    import sm83_alu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   opcode,
    input  logic [DATA_W-1:0] acc_value,
    input  logic [DATA_W-1:0] operand,
    input  logic [FLAG_W-1:0] flags_in,
    output logic              done,
    output logic [DATA_W-1:0] result,
    output logic [FLAG_W-1:0] flags_out
);

    alu_req_t          req_reg;
    logic              req_vld_reg;
    logic              done_reg;
    logic [DATA_W-1:0] result_reg;
    logic [FLAG_W-1:0] flags_reg;
    logic [DATA_W-1:0] result_next;
    logic [FLAG_W-1:0] flags_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            req_vld_reg <= start && !busy;
            done_reg    <= req_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg.opcode    <= opcode;
            req_reg.acc_value <= acc_value;
            req_reg.operand   <= operand;
            req_reg.flags_in  <= flags_in;
        end
        if (req_vld_reg)
        begin
            result_reg <= result_next;
            flags_reg  <= flags_next;
        end
    end

    always_comb
    begin
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic              cin;
        logic              t;
        logic [DATA_W:0]   sum9;
        logic [4:0]        sum5;
        logic [DATA_W:0]   dif9;
        logic [4:0]        dif5;
        logic [DATA_W-1:0] daa_v;
        logic              daa_c;
        logic [DATA_W-1:0] r;

        a   = req_reg.acc_value;
        b   = req_reg.operand;
        cin = req_reg.flags_in[FLAG_C];
        t   = (req_reg.opcode inside {OP_ADC, OP_SBC}) ? cin : 1'b0;

        sum9 = {1'b0, a} + {1'b0, b} + {{DATA_W{1'b0}}, t};
        sum5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, t};
        dif9 = {1'b0, a} - {1'b0, b} - {{DATA_W{1'b0}}, t};
        dif5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, t};

        // Decimal adjust: the low-nibble test sees the value after the high fix,
        // whose low nibble is unchanged
        daa_v = a;
        daa_c = cin;
        if (!req_reg.flags_in[FLAG_N])
        begin
            if (cin || (a > BCD_MAX))
            begin
                daa_v = daa_v + DAA_HI;
                daa_c = 1'b1;
            end
            if (req_reg.flags_in[FLAG_H] || (daa_v[3:0] > NIB_MAX))
                daa_v = daa_v + DAA_LO;
        end
        else
        begin
            if (cin)
                daa_v = daa_v - DAA_HI;
            if (req_reg.flags_in[FLAG_H])
                daa_v = daa_v - DAA_LO;
        end

        r           = a;
        result_next = a;
        flags_next  = req_reg.flags_in;

        case (req_reg.opcode)
            OP_ADD, OP_ADC:
            begin
                r           = sum9[DATA_W-1:0];
                result_next = r;
                flags_next  = {(r == '0), 1'b0, sum5[4], sum9[DATA_W]};
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                r = dif9[DATA_W-1:0];
                result_next = (req_reg.opcode == OP_CP) ? a : r;
                flags_next  = {(r == '0), 1'b1, dif5[4], dif9[DATA_W]};
            end
            OP_AND:
            begin
                r           = a & b;
                result_next = r;
                flags_next  = {(r == '0), 1'b0, 1'b1, 1'b0};
            end
            OP_XOR:
            begin
                r           = a ^ b;
                result_next = r;
                flags_next  = {(r == '0), 3'b000};
            end
            OP_OR:
            begin
                r           = a | b;
                result_next = r;
                flags_next  = {(r == '0), 3'b000};
            end
            OP_INC:
            begin
                r           = b + 8'd1;
                result_next = r;
                flags_next  = {(r == '0), 1'b0, (r[3:0] == 4'h0), cin};
            end
            OP_DEC:
            begin
                r           = b - 8'd1;
                result_next = r;
                flags_next  = {(r == '0), 1'b1, (r[3:0] == 4'hF), cin};
            end
            OP_RLCA:
            begin
                result_next = {a[DATA_W-2:0], a[DATA_W-1]};
                flags_next  = {3'b000, a[DATA_W-1]};
            end
            OP_RRCA:
            begin
                result_next = {a[0], a[DATA_W-1:1]};
                flags_next  = {3'b000, a[0]};
            end
            OP_RLA:
            begin
                result_next = {a[DATA_W-2:0], cin};
                flags_next  = {3'b000, a[DATA_W-1]};
            end
            OP_RRA:
            begin
                result_next = {cin, a[DATA_W-1:1]};
                flags_next  = {3'b000, a[0]};
            end
            OP_DAA:
            begin
                result_next = daa_v;
                flags_next  = {(daa_v == '0), req_reg.flags_in[FLAG_N], 1'b0, daa_c};
            end
            OP_CPL:
            begin
                result_next = ~a;
                flags_next  = {req_reg.flags_in[FLAG_Z], 2'b11, cin};
            end
            OP_SCF:
                flags_next = {req_reg.flags_in[FLAG_Z], 3'b001};
            OP_CCF:
                flags_next = {req_reg.flags_in[FLAG_Z], 2'b00, ~cin};
            default:
            begin
                // Unused codes pass the accumulator and flags through
                result_next = a;
                flags_next  = req_reg.flags_in;
            end
        endcase
    end

    assign done      = done_reg;
    assign result    = result_reg;
    assign flags_out = flags_reg;

endmodule

/* rtl/sm83_alu_chk.sv */
// ----------------------------------------------------------------------------
// sm83_alu_chk
// Port-level checks of the ALU pipeline timing and a few flag rules.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sm83_alu_chk
    import sm83_alu_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic [OP_W-1:0]   opcode,
    input logic [DATA_W-1:0] acc_value,
    input logic [DATA_W-1:0] operand,
    input logic [FLAG_W-1:0] flags_in,
    input logic              done,
    input logic [DATA_W-1:0] result,
    input logic [FLAG_W-1:0] flags_out
);

    logic acc_xfer;

    assign acc_xfer = start && !busy && rst_n;

    `ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)

    // Every transfer gives a strobe through the input and result registers
    `ASSERT_IMPLY(a_done_follows, clk, rst_n, $past(acc_xfer, 2) && $past(rst_n, 1), done)

    // No strobe without a matching transfer
    `ASSERT_IMPLY(a_done_cause, clk, rst_n, done, $past(acc_xfer, 2))

    // Set carry always shows C=1, N=0, H=0 and keeps Z
    `ASSERT_IMPLY(a_scf_flags, clk, rst_n, done && $past(acc_xfer && opcode == OP_SCF, 2), flags_out[FLAG_C] && !flags_out[FLAG_N] && !flags_out[FLAG_H] && (flags_out[FLAG_Z] == $past(flags_in[FLAG_Z], 2)))

    // Compare leaves the accumulator untouched and sets N
    `ASSERT_IMPLY(a_cp_keeps_acc, clk, rst_n, done && $past(acc_xfer && opcode == OP_CP, 2), (result == $past(acc_value, 2)) && flags_out[FLAG_N])

endmodule

bind sm83_alu_with_flags_top sm83_alu_chk u_sm83_alu_chk (.*);

/* test/sm83_alu_with_flags_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm83_alu_with_flags_checker
// Watches the command and result channels of the SM83 ALU, predicts the value
// and Z/N/H/C flags of every accepted command and compares them in order
// with the results that come out of the block.
// ----------------------------------------------------------------------------
module sm83_alu_with_flags_checker
    import sm83_alu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [OP_W-1:0]   opcode,
    input  logic [DATA_W-1:0] acc_value,
    input  logic [DATA_W-1:0] operand,
    input  logic [FLAG_W-1:0] flags_in,
    input  logic              done,
    input  logic [DATA_W-1:0] result,
    input  logic [FLAG_W-1:0] flags_out,
    output int                fail_count,
    output int                pending
);

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [FLAG_W-1:0] flags;
    } alu_out_t;

    alu_out_t alu_out_q[$];
    int       mismatches = 0;

    function automatic alu_out_t alu_compute(
        input logic [OP_W-1:0]   op,
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b,
        input logic [FLAG_W-1:0] f
    );
        alu_out_t           res;
        logic [DATA_W:0]    wide;
        logic [4:0]         nib;
        logic               cin;
        logic               cy;
        logic [DATA_W-1:0]  r;
        logic [FLAG_W-1:0]  nf;
        cin = f[FLAG_C];
        r   = a;
        nf  = f;
        case (op)
            OP_ADD, OP_ADC:
            begin
                cy   = (op == OP_ADC) ? cin : 1'b0;
                wide = {1'b0, a} + {1'b0, b} + {{DATA_W{1'b0}}, cy};
                nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cy};
                r    = wide[DATA_W-1:0];
                nf   = '0;
                nf[FLAG_H] = nib[4];
                nf[FLAG_C] = wide[DATA_W];
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                // bit 8 / bit 4 of the wrapped difference is the borrow
                cy   = (op == OP_SBC) ? cin : 1'b0;
                wide = {1'b0, a} - {1'b0, b} - {{DATA_W{1'b0}}, cy};
                nib  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, cy};
                r    = wide[DATA_W-1:0];
                nf   = '0;
                nf[FLAG_N] = 1'b1;
                nf[FLAG_H] = nib[4];
                nf[FLAG_C] = wide[DATA_W];
            end
            OP_AND:
            begin
                r  = a & b;
                nf = '0;
                nf[FLAG_H] = 1'b1;
            end
            OP_XOR:
            begin
                r  = a ^ b;
                nf = '0;
            end
            OP_OR:
            begin
                r  = a | b;
                nf = '0;
            end
            OP_INC:
            begin
                r  = b + 8'd1;
                nf = '0;
                nf[FLAG_H] = (r[3:0] == 4'h0);
                nf[FLAG_C] = cin;
            end
            OP_DEC:
            begin
                r  = b - 8'd1;
                nf = '0;
                nf[FLAG_N] = 1'b1;
                nf[FLAG_H] = (r[3:0] == 4'hF);
                nf[FLAG_C] = cin;
            end
            OP_RLCA:
            begin
                r  = {a[6:0], a[7]};
                nf = '0;
                nf[FLAG_C] = a[7];
            end
            OP_RRCA:
            begin
                r  = {a[0], a[7:1]};
                nf = '0;
                nf[FLAG_C] = a[0];
            end
            OP_RLA:
            begin
                r  = {a[6:0], cin};
                nf = '0;
                nf[FLAG_C] = a[7];
            end
            OP_RRA:
            begin
                r  = {cin, a[7:1]};
                nf = '0;
                nf[FLAG_C] = a[0];
            end
            OP_DAA:
            begin
                cy = cin;
                if (!f[FLAG_N]) begin
                    if (cy || r > 8'h99) begin
                        r  = r + 8'h60;
                        cy = 1'b1;
                    end
                    if (f[FLAG_H] || r[3:0] > 4'h9)
                        r = r + 8'h06;
                end
                else begin
                    if (cy)
                        r = r - 8'h60;
                    if (f[FLAG_H])
                        r = r - 8'h06;
                end
                nf = '0;
                nf[FLAG_N] = f[FLAG_N];
                nf[FLAG_C] = cy;
            end
            OP_CPL:
            begin
                r  = ~a;
                nf = f;
                nf[FLAG_N] = 1'b1;
                nf[FLAG_H] = 1'b1;
            end
            OP_SCF:
            begin
                nf = '0;
                nf[FLAG_Z] = f[FLAG_Z];
                nf[FLAG_C] = 1'b1;
            end
            OP_CCF:
            begin
                nf = '0;
                nf[FLAG_Z] = f[FLAG_Z];
                nf[FLAG_C] = ~cin;
            end
            default:
            begin
                // undefined codes pass accumulator and flags through
            end
        endcase
        // Z follows the 8-bit outcome (the difference for CP) for ADD through DEC and DAA
        if (op <= OP_DAA) begin
            if (op == OP_CP)
                nf[FLAG_Z] = (r == '0);
            else if (op < OP_RLCA || op == OP_DAA)
                nf[FLAG_Z] = (r == '0);
        end
        if (op == OP_CP)
            r = a;
        res.value = r;
        res.flags = nf;
        return res;
    endfunction

    always @(posedge clk) begin
        alu_out_t exp_out;
        if (rst_n) begin
            if (start && !busy)
                alu_out_q.push_back(alu_compute(opcode, acc_value, operand, flags_in));
            if (done) begin
                if (alu_out_q.size() == 0) begin
                    $error("result: transfer with nothing expected, got %h / %h",
                           result, flags_out);
                    mismatches++;
                end
                else begin
                    exp_out = alu_out_q.pop_front();
                    if (result !== exp_out.value) begin
                        $error("result: expected %h, got %h", exp_out.value, result);
                        mismatches++;
                    end
                    if (flags_out !== exp_out.flags) begin
                        $error("flags_out: expected %b, got %b", exp_out.flags, flags_out);
                        mismatches++;
                    end
                end
            end
        end
        pending    <= alu_out_q.size();
        fail_count <= mismatches;
    end

endmodule

/* test/sm83_alu_with_flags_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm83_alu_with_flags_top_tb
// Drives directed corner commands and then random ones, with random gaps and
// bursts, into the SM83 ALU; the checker beside the block predicts and
// compares every result and this module gives the verdict.
// ----------------------------------------------------------------------------
module sm83_alu_with_flags_top_tb;
    import sm83_alu_pkg::*;

    localparam logic [OP_W-1:0] OP_UNDEF_MAX = 5'd31;
    localparam int RAND_ITEMS = 1500;
    localparam int MAX_GAP    = 18;
    localparam int CYCLE_LIMIT = 200000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [OP_W-1:0]   opcode = '0;
    logic [DATA_W-1:0] acc_value = '0;
    logic [DATA_W-1:0] operand = '0;
    logic [FLAG_W-1:0] flags_in = '0;
    logic              done;
    logic [DATA_W-1:0] result;
    logic [FLAG_W-1:0] flags_out;
    int                fail_count;
    int                pending;
    int                cycle_cnt = 0;
    bit                burst_mode = 1'b0;

    always #5 clk = ~clk;

    sm83_alu_with_flags_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .acc_value (acc_value),
        .operand   (operand),
        .flags_in  (flags_in),
        .done      (done),
        .result    (result),
        .flags_out (flags_out)
    );

    sm83_alu_with_flags_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .acc_value  (acc_value),
        .operand    (operand),
        .flags_in   (flags_in),
        .done       (done),
        .result     (result),
        .flags_out  (flags_out),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // one command transfer; start stays high when no gap follows
    task automatic issue_op(
        input logic [OP_W-1:0]   op,
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b,
        input logic [FLAG_W-1:0] f
    );
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        opcode    <= op;
        acc_value <= a;
        operand   <= b;
        flags_in  <= f;
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic logic [DATA_W-1:0] pick_byte();
        logic [DATA_W-1:0] corners [8];
        corners = '{8'h00, 8'hFF, 8'h0F, 8'h10, 8'h80, 8'h7F, 8'h99, 8'h9A};
        if ($urandom_range(0, 3) == 0)
            return corners[$urandom_range(0, 7)];
        return DATA_W'($urandom);
    endfunction

    initial begin
        logic [OP_W-1:0] op;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        issue_op(OP_ADD,  8'hFF, 8'h01, 4'h0);
        issue_op(OP_ADC,  8'h0F, 8'h00, 4'h1);
        issue_op(OP_ADD,  8'h00, 8'h00, 4'hF);
        issue_op(OP_SUB,  8'h00, 8'h01, 4'h0);
        issue_op(OP_SBC,  8'h10, 8'h0F, 4'h1);
        issue_op(OP_CP,   8'h42, 8'h42, 4'h0);
        issue_op(OP_AND,  8'hF0, 8'h0F, 4'hF);
        issue_op(OP_XOR,  8'hFF, 8'hFF, 4'h0);
        issue_op(OP_OR,   8'h00, 8'h00, 4'hF);
        issue_op(OP_INC,  8'h12, 8'hFF, 4'h1);
        issue_op(OP_INC,  8'h00, 8'h0F, 4'h0);
        issue_op(OP_DEC,  8'hAA, 8'h00, 4'h1);
        issue_op(OP_DEC,  8'h55, 8'h01, 4'h0);
        issue_op(OP_RLCA, 8'h80, 8'h00, 4'hF);
        issue_op(OP_RRCA, 8'h01, 8'hFF, 4'h0);
        issue_op(OP_RLA,  8'h80, 8'h00, 4'h1);
        issue_op(OP_RRA,  8'h01, 8'h00, 4'hE);
        issue_op(OP_DAA,  8'h9A, 8'h00, 4'h0);
        issue_op(OP_DAA,  8'hFF, 8'h00, 4'h3);
        issue_op(OP_DAA,  8'h00, 8'h00, 4'h7);
        issue_op(OP_DAA,  8'h45, 8'h00, 4'h4);
        issue_op(OP_CPL,  8'h55, 8'h00, 4'hF);
        issue_op(OP_SCF,  8'h00, 8'h00, 4'h8);
        issue_op(OP_CCF,  8'hFF, 8'hFF, 4'h1);
        issue_op(OP_UNDEF_MAX, 8'hA5, 8'h5A, 4'hF);

        // random part; bursts of back-to-back transfers every so often
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i % 50 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                op = OP_W'($urandom_range(OP_CCF + 1, OP_UNDEF_MAX));
            else
                op = OP_W'($urandom_range(OP_ADD, OP_CCF));
            issue_op(op, pick_byte(), pick_byte(), FLAG_W'($urandom));
        end
        start <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/sm83_alu_pkg.sv
rtl/sm83_alu_with_flags_top.sv
rtl/sm83_alu_chk.sv
test/sm83_alu_with_flags_checker.sv
test/sm83_alu_with_flags_top_tb.sv
